### sv/wvm_pkg.sv
package wvm_pkg;

	// command codes carried in s_tuser
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_SET   = 2'd1,
		CMD_TABLE = 2'd2
	} cmd_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET_RED,
		ST_SET_WR,
		ST_TBL_WR,
		ST_V_PH,
		ST_V_TB,
		ST_V_MUL,
		ST_V_ACC,
		ST_DONE
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch the input word
		logic red_step;  // one restoring step of the increment reduction
		logic vsel_item; // voice RAM read address from the latched voice slot
		logic set_wr;    // write the voice record of a set-voice word
		logic tbl_wr;    // write one wavetable word
		logic vcnt_clr;  // restart voice walk, clear the mix sum
		logic phase_en;  // advance phase of the current voice
		logic mul_en;    // select sample and scale by level
		logic acc_en;    // accumulate, write back, go to next voice
		logic out_load;  // place the finished DAC code in the output register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic red_last;
		logic vcnt_last;
		logic out_free;
	} dp_stat_t;

	localparam int VOL_SHIFT = 4;
	localparam int MIX_SHIFT = 10;
	localparam int DAC_MID   = 2048;
	localparam int DAC_MAX   = 4095;
	localparam int DAC_W     = 12;
	localparam int STEP_W    = 26;

endpackage

### sv/wvm_ram.sv
module wvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/wvm_ctrl.sv
module wvm_ctrl
	import wvm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_cmd,
	output logic       in_ready,
	input  dp_stat_t   stat,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (cmd_t'(in_cmd))
						CMD_TICK: begin
							cmd.vcnt_clr = 1'b1;
							state_d      = ST_V_PH;
						end
						CMD_SET:   state_d = ST_SET_RED;
						CMD_TABLE: state_d = ST_TBL_WR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_SET_RED: begin
				cmd.vsel_item = 1'b1;
				cmd.red_step  = 1'b1;
				if (stat.red_last) begin
					state_d = ST_SET_WR;
				end
			end
			ST_SET_WR: begin
				cmd.vsel_item = 1'b1;
				cmd.set_wr    = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_TBL_WR: begin
				cmd.tbl_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_V_PH: begin
				cmd.phase_en = 1'b1;
				state_d      = ST_V_TB;
			end
			ST_V_TB: begin
				state_d = ST_V_MUL;
			end
			ST_V_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_V_ACC;
			end
			ST_V_ACC: begin
				cmd.acc_en = 1'b1;
				state_d    = stat.vcnt_last ? ST_DONE : ST_V_PH;
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/wvm_dp.sv
module wvm_dp
	import wvm_pkg::*;
#(
	parameter int VOICE_COUNT = 16,
	parameter int TABLE_SIZE  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output dp_stat_t    stat,
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata
);

	// widths
	localparam int VI_W      = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int AW        = $clog2(TABLE_SIZE);
	localparam int PW        = AW + 16;
	localparam int RED_STEPS = (PW < STEP_W + 1) ? STEP_W + 1 - PW : 1;
	localparam int RW        = ((PW > STEP_W) ? PW : STEP_W) + 1;
	localparam int RC_W      = $clog2(RED_STEPS + 1);
	localparam int SUM_W     = 24 + $clog2(VOICE_COUNT);
	localparam int SH_W      = SUM_W - MIX_SHIFT;

	// voice record layout
	localparam int PH_LO  = 0;
	localparam int INC_LO = PW;
	localparam int LVL_LO = 2 * PW;
	localparam int HLD_LO = 2 * PW + 7;
	localparam int ON_BIT = 2 * PW + 23;
	localparam int REC_W  = 2 * PW + 24;

	localparam logic [RW-1:0] LIMIT_R  = RW'(TABLE_SIZE) << 16;
	localparam logic [RW-1:0] LIM_TOP  = LIMIT_R << (RED_STEPS - 1);
	localparam logic [PW:0]   LIMIT_P  = (PW + 1)'(TABLE_SIZE) << 16;
	localparam logic signed [SH_W-1:0] CODE_HI = SH_W'(DAC_MID - 1);
	localparam logic signed [SH_W-1:0] CODE_LO = SH_W'(-DAC_MID);

	// latched input word
	logic [3:0]        item_idx_q;
	logic              item_en_q;
	logic [6:0]        item_vol_q;
	logic [9:0]        item_addr_q;
	logic [15:0]       item_val_q;
	logic [RW-1:0]     red_q;
	logic [RW-1:0]     lim_q;
	logic [RC_W-1:0]   rcnt_q;

	// voice walk
	logic [VI_W-1:0]   vcnt_q, vcnt_next;
	logic [VOICE_COUNT-1:0] vvalid_q;
	logic              valid_s1;
	logic [REC_W-1:0]  vram_rdata, rec_rd, rec_s1, rec_wdata;
	logic [VI_W-1:0]   vram_raddr, vram_waddr;
	logic              vram_we;
	logic [PW-1:0]     phase_s1;
	logic [PW:0]       psum, pwrap;

	// table and mix
	logic [15:0]       tbl_rdata;
	logic [15:0]       sample;
	logic [15:0]       sample_s2;
	logic signed [23:0] prod_s2;
	logic signed [SUM_W-1:0] sum_q, contrib;
	logic signed [SH_W-1:0]  shifted;
	logic [DAC_W-1:0]  code;
	logic [DAC_W-1:0]  dac_q;
	logic              out_valid_q;
	logic              set_ok, tbl_ok;
	logic              rec_on;
	logic [6:0]        rec_lvl, lvl_new;

	assign set_ok = 32'(item_idx_q) < 32'(VOICE_COUNT);
	assign tbl_ok = 32'(item_addr_q) < 32'(TABLE_SIZE);

	// voice counter and read address for the next cycle
	always_comb begin
		if (cmd.vcnt_clr) begin
			vcnt_next = '0;
		end else if (cmd.acc_en) begin
			vcnt_next = VI_W'(vcnt_q + 1'b1);
		end else begin
			vcnt_next = vcnt_q;
		end
		vram_raddr = cmd.vsel_item ? VI_W'(item_idx_q) : vcnt_next;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q      <= '0;
			rcnt_q      <= '0;
			vvalid_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vcnt_q   <= vcnt_next;
			valid_s1 <= vvalid_q[vram_raddr];
			if (cmd.load) begin
				rcnt_q <= '0;
			end else if (cmd.red_step) begin
				rcnt_q <= RC_W'(rcnt_q + 1'b1);
			end
			if (vram_we) begin
				vvalid_q[vram_waddr] <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// an unwritten voice reads as all zero
	assign rec_rd  = valid_s1 ? vram_rdata : '0;
	assign rec_on  = rec_s1[ON_BIT];
	assign rec_lvl = rec_s1[LVL_LO +: 7];

	// phase advance with wrap at the table length
	always_comb begin
		psum  = {1'b0, rec_rd[PH_LO +: PW]} + {1'b0, rec_rd[INC_LO +: PW]};
		pwrap = (psum >= LIMIT_P) ? psum - LIMIT_P : psum;
	end

	assign sample  = rec_on ? tbl_rdata : rec_s1[HLD_LO +: 16];
	assign lvl_new = (!rec_on && rec_lvl != 7'd0) ? rec_lvl - 7'd1 : rec_lvl;
	assign contrib = SUM_W'(prod_s2 >>> VOL_SHIFT);

	// voice record write back
	always_comb begin
		if (cmd.set_wr) begin
			vram_waddr = VI_W'(item_idx_q);
			vram_we    = set_ok;
			rec_wdata  = {item_en_q, rec_rd[HLD_LO +: 16], item_vol_q,
				red_q[PW-1:0], rec_rd[PH_LO +: PW]};
		end else begin
			vram_waddr = vcnt_q;
			vram_we    = cmd.acc_en;
			rec_wdata  = {rec_on, sample_s2, lvl_new, rec_s1[INC_LO +: PW],
				rec_on ? phase_s1 : rec_s1[PH_LO +: PW]};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_idx_q  <= s_tdata[3:0];
			item_en_q   <= s_tdata[4];
			item_vol_q  <= s_tdata[37:31];
			item_addr_q <= s_tdata[47:38];
			item_val_q  <= s_tdata[63:48];
			red_q       <= RW'(s_tdata[30:5]);
			lim_q       <= LIM_TOP;
		end else if (cmd.red_step) begin
			if (red_q >= lim_q) begin
				red_q <= red_q - lim_q;
			end
			lim_q <= lim_q >> 1;
		end
		if (cmd.phase_en) begin
			rec_s1   <= rec_rd;
			phase_s1 <= pwrap[PW-1:0];
		end
		if (cmd.mul_en) begin
			sample_s2 <= sample;
			prod_s2   <= 24'($signed(sample)) * 24'($signed({1'b0, rec_lvl}));
		end
		if (cmd.vcnt_clr) begin
			sum_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q <= sum_q + contrib;
		end
		if (cmd.out_load) begin
			dac_q <= code;
		end
	end

	// final scale, offset and clamp
	always_comb begin
		shifted = SH_W'(sum_q >>> MIX_SHIFT);
		if (shifted > CODE_HI) begin
			code = DAC_W'(DAC_MAX);
		end else if (shifted < CODE_LO) begin
			code = '0;
		end else begin
			code = shifted[DAC_W-1:0] ^ DAC_W'(DAC_MID);
		end
	end

	wvm_ram #(
		.WIDTH(REC_W),
		.DEPTH(VOICE_COUNT)
	) u_voice_ram (
		.clk  (clk),
		.we   (vram_we),
		.waddr(vram_waddr),
		.wdata(rec_wdata),
		.raddr(vram_raddr),
		.rdata(vram_rdata)
	);

	wvm_ram #(
		.WIDTH(16),
		.DEPTH(TABLE_SIZE)
	) u_wave_ram (
		.clk  (clk),
		.we   (cmd.tbl_wr && tbl_ok),
		.waddr(AW'(item_addr_q)),
		.wdata(item_val_q),
		.raddr(phase_s1[PW-1:16]),
		.rdata(tbl_rdata)
	);

	assign stat.red_last  = rcnt_q == RC_W'(RED_STEPS - 1);
	assign stat.vcnt_last = vcnt_q == VI_W'(VOICE_COUNT - 1);
	assign stat.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(16 - DAC_W){1'b0}}, dac_q};

endmodule

### sv/wavetable_voice_mixer_core.sv
// channel | dir | fields (tdata / tuser, low bit up)
// s_      | in  | tdata: voice_index[3:0] voice_enable[4] phase_step[30:5]
//         |     |        voice_volume[37:31] table_address[47:38] table_value[63:48]
//         |     | tuser: command[1:0]
// m_      | out | tdata: dac_sample[11:0], zero fill [15:12]
//
// A tick word walks each voice in turn, voice RAM read, phase add, wavetable read,
// multiply, accumulate, through one shared unit.
// A set-voice word runs RED_STEPS restoring steps, reducing the phase step modulo the
// table length, before its voice record is written.
// Reset clears all voices at once through per-voice valid bits; the wavetable is not cleared.
// A new word is taken while a DAC code still waits on m_; a tick holds at its end
// only while the output register is full.
module wavetable_voice_mixer_core
	import wvm_pkg::*;
#(
	parameter int VOICE_COUNT = 16,
	parameter int TABLE_SIZE  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // voice_index, voice_enable, phase_step, voice_volume,
	                              // table_address, table_value
	input  logic [1:0]  s_tuser,  // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // dac_sample
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	wvm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_cmd  (s_tuser),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	wvm_dp #(
		.VOICE_COUNT(VOICE_COUNT),
		.TABLE_SIZE (TABLE_SIZE)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
